// File: rtl/pls_pkg.sv
// shared types and constants for the positional list store
package pls_pkg;

    // fixed field widths of the stream beats
    localparam int CMD_W       = 3;
    localparam int POS_W       = 5;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 72;

    // input beat field offsets
    localparam int CMD_LSB     = 0;
    localparam int POS_LSB     = 3;
    localparam int VALUE_LSB   = 8;

    // command codes; unused codes act as read
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_DROP   = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_BADPOS = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_POS,
        S_RD_LAST,
        S_PUBLISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_pos;
        logic rd_last;
        logic publish;
    } pls_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } pls_sts_t;

endpackage

// File: rtl/pls_ctrl.sv
// command sequencer for the positional list store
module pls_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pls_pkg::pls_sts_t   sts,
    output pls_pkg::pls_ctrl_t  ctrl
);
    import pls_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:    state_next = S_RD_POS;
            S_RD_POS:  state_next = S_RD_LAST;
            S_RD_LAST: state_next = S_PUBLISH;
            S_PUBLISH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = 1'b0;
        ctrl         = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            S_EXEC:    ctrl.exec    = 1'b1;
            S_RD_POS:  ctrl.rd_pos  = 1'b1;
            S_RD_LAST: ctrl.rd_last = 1'b1;
            S_PUBLISH: ctrl.publish = sts.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/pls_dpath.sv
// entry register file, count, read port and result register of the list store
module pls_dpath #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pls_pkg::pls_ctrl_t                ctrl,
    output pls_pkg::pls_sts_t                 sts,
    input  logic [pls_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pls_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pls_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // latched command beat
    logic [CMD_W-1:0]   cmd_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [WIDTH-1:0]   value_reg;

    // list state
    logic [WIDTH-1:0]   entries_reg  [DEPTH];
    logic [WIDTH-1:0]   entries_next [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // result staging
    status_t            status_reg;
    status_t            status_next;
    logic [DATA_W-1:0]  rd_value_reg;
    logic [DATA_W-1:0]  last_value_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;

    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   ins_pos;
    logic               full;
    logic               empty;
    logic               do_ins;
    logic               do_drop;
    logic               do_erase;
    logic [IDX_W-1:0]   rd_addr;
    logic [WIDTH-1:0]   rd_word;
    logic [DATA_W-1:0]  rd_word_ext;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (cnt_ext >= CMP_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // capture the accepted beat
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg   <= s_tdata[CMD_LSB +: CMD_W];
            pos_reg   <= s_tdata[POS_LSB +: POS_W];
            value_reg <= WIDTH'(64'(s_tdata[VALUE_LSB +: DATA_W]));
        end
    end

    // command decode and status
    always_comb begin
        status_next = STS_OK;
        do_ins      = 1'b0;
        do_drop     = 1'b0;
        do_erase    = 1'b0;
        ins_pos     = cnt_ext;
        case (cmd_t'(cmd_reg))
            CMD_APPEND: begin
                if (full) begin
                    status_next = STS_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_DROP: begin
                if (empty) begin
                    status_next = STS_EMPTY;
                end else begin
                    do_drop = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    status_next = STS_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status_next = STS_BADPOS;
                end else begin
                    do_ins  = 1'b1;
                    ins_pos = pos_ext;
                end
            end
            CMD_ERASE: begin
                if (empty) begin
                    status_next = STS_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status_next = STS_BADPOS;
                end else begin
                    do_erase = 1'b1;
                end
            end
            default: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = STS_BADPOS;
                end
            end
        endcase
    end

    // parallel shift of every cell
    always_comb begin
        entries_next = entries_reg;
        if (do_ins) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (CMP_W'(i) > ins_pos) begin
                    entries_next[i] = entries_reg[i-1];
                end
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (CMP_W'(i) == ins_pos) begin
                    entries_next[i] = value_reg;
                end
            end
        end else if (do_erase) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (CMP_W'(i) >= pos_ext) begin
                    entries_next[i] = entries_reg[i+1];
                end
            end
        end
    end

    // count update
    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + 1'b1;
        end else if (do_drop || do_erase) begin
            count_next = count_reg - 1'b1;
        end
    end

    // entry cells hold no reset value
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            entries_reg <= entries_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            status_reg <= status_next;
        end
    end

    // single read port, shared by position and last entry lookups
    assign rd_addr     = ctrl.rd_pos ? IDX_W'(pos_reg) : IDX_W'(count_reg - 1'b1);
    assign rd_word     = entries_reg[rd_addr];
    assign rd_word_ext = DATA_W'(64'(rd_word));

    always_ff @(posedge aclk) begin
        if (ctrl.rd_pos) begin
            rd_value_reg <= (pos_ext < cnt_ext) ? rd_word_ext : '0;
        end
        if (ctrl.rd_last) begin
            last_value_reg <= empty ? '0 : rd_word_ext;
        end
    end

    // result beat, packed high field first
    assign m_tdata_next = {1'b0, status_reg, COUNT_W'(count_reg),
                           last_value_reg, rd_value_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.publish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

// File: rtl/positional_list_store.sv
// top level of the positional list store
// sequence: a taken command beat passes the execute, position read and last read states,
//   then its result beat is offered once the output register is free; no new command
//   is taken until then; the work is the cell update and two lookups through the one read port
// reset: aresetn synchronous, active low; empties the list and drops any
//   pending result; entry contents are not cleared
module positional_list_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[2:0], position[7:3], value[39:8]
    input  logic [pls_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0], last_value[63:32], count[68:64], status[70:69], zero[71]
    output logic [pls_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pls_pkg::*;

    pls_ctrl_t ctrl;
    pls_sts_t  sts;

    pls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctrl     (ctrl)
    );

    pls_dpath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
